### rtl/lzss_pkg.sv
// Package for the LZSS byte stream decompressor: decode phases, control states, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lzss_pkg;
  localparam int WindowBytesDef = 8192;
  localparam int CountBitsDef   = 24;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_KIND = 3'd1,
    PH_LEN  = 3'd2,
    PH_LIT  = 3'd3,
    PH_SOFF = 3'd4,
    PH_WLO  = 3'd5,
    PH_WHI  = 3'd6,
    PH_EXT  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_COPY = 2'd1,
    ST_EMIT = 2'd2
  } ctl_state_t;
endpackage
`default_nettype wire

### rtl/lzss_byte_stream_decompressor.sv
// Top level of the LZSS byte stream decompressor: header decode, history
// memory and match copy engine. Depends on lzss_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | tdata fields (low bit up)                 | tuser / tlast
// in_     | in  | comp_byte[7:0]                            | tuser: new_stream
// out_    | out | byte_0..byte_3, byte_count(3), stream_end, | tlast: last_of_run
//         |     | bad_reference, total_bytes(24), pad to 64 |
//
// One compressed word is taken in ST_IDLE and its header bits are decoded in
// that cycle; a word that yields no output frees the input again next cycle.
// A literal or end/bad marker goes through ST_EMIT before the input is free again.
// A match of length L reads and writes back the single-port history memory one
// byte at a time, with no new read until the last byte is written back, and goes
// out through ST_EMIT in output words of up to four bytes.
// ST_EMIT holds while the output register is full and not taken, and the input
// stalls until the whole match is out.
// Reset clears control state only; history needs no clearing because only
// entries below the written count are read.
module lzss_byte_stream_decompressor #(
  parameter int WINDOW_BYTES = lzss_pkg::WindowBytesDef,
  parameter int COUNT_BITS   = lzss_pkg::CountBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // comp_byte
  input  wire logic        in_tuser,   // new_stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // byte_0[7:0] byte_1[15:8] byte_2[23:16] byte_3[31:24] byte_count[34:32]
  // stream_end[35] bad_reference[36] total_bytes[60:37], zeros above
  output logic [63:0]      out_tdata,
  output logic             out_tlast   // last_of_run
);
  localparam int AW = $clog2(WINDOW_BYTES);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [7:0] ctrl_r;
  logic [3:0] bits_r;
  lzss_pkg::phase_t ph_r;
  logic [1:0] lenf_r;
  logic [7:0] wlo_r;
  logic [13:0] dist_r;
  logic [8:0] rem_r;
  logic [8:0] hrm_r;     // length bits taken, restored once a match is out
  logic [AW-1:0] wp_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic stop_r;
  lzss_pkg::ctl_state_t st_r;

  logic [7:0] hist [WINDOW_BYTES];
  logic [7:0] rdata_r;
  logic rd_pend_r;       // a read issued last cycle
  logic fwd_r;           // read address equals last written address
  logic [7:0] fwd_d_r;
  logic [7:0] lastw_r;   // last byte written

  logic [7:0] grp_r [4];
  logic [2:0] gcnt_r;
  logic end_r, bad_r, last_r;
  logic obuf_v_r;
  logic [63:0] obuf_r;
  logic obuf_l_r;

  // ---- header advance for one control-bit run (at most 4 bits) ----
  function automatic void adv(
    input lzss_pkg::phase_t p, input logic [7:0] c, input logic [3:0] b,
    input logic [1:0] lf, input logic [8:0] rm,
    output lzss_pkg::phase_t po, output logic [7:0] co, output logic [3:0] bo,
    output logic [1:0] lfo, output logic [8:0] rmo);
    logic bit_v;
    po = p; co = c; bo = b; lfo = lf; rmo = rm;
    for (int i = 0; i < 4; i++) begin
      if ((po == lzss_pkg::PH_TYPE || po == lzss_pkg::PH_KIND ||
           po == lzss_pkg::PH_LEN) && bo != 4'd0) begin
        bit_v = co[0];
        co = {1'b0, co[7:1]};
        bo = bo - 4'd1;
        if (po == lzss_pkg::PH_TYPE) begin
          po = bit_v ? lzss_pkg::PH_LIT : lzss_pkg::PH_KIND;
        end else if (po == lzss_pkg::PH_KIND) begin
          if (bit_v) begin
            po = lzss_pkg::PH_WLO;
          end else begin
            po = lzss_pkg::PH_LEN; lfo = 2'd0; rmo = 9'd0;
          end
        end else begin
          lfo = {lfo[0], bit_v};
          rmo = rmo + 9'd1;
          if (rmo >= 9'd2) po = lzss_pkg::PH_SOFF;
        end
      end
    end
  endfunction

  // ---- accept logic (combinational, IDLE only) ----
  logic acc;
  assign in_tready = (st_r == lzss_pkg::ST_IDLE);
  assign acc = in_tvalid && in_tready;

  lzss_pkg::phase_t a_ph, h_ph;
  logic [7:0] a_ctrl, h_ctrl;
  logic [3:0] a_bits, h_bits;
  logic [1:0] a_lf, h_lf;
  logic [8:0] a_rm, h_rm;
  logic a_stop;
  logic [COUNT_BITS-1:0] a_cnt;
  logic lit, mstart, endm, badm;
  logic [13:0] mdist;
  logic [8:0] mlen;
  logic [15:0] wrd;

  always_comb begin
    a_ph = ph_r; a_ctrl = ctrl_r; a_bits = bits_r; a_lf = lenf_r; a_rm = rem_r;
    a_stop = stop_r; a_cnt = cnt_r;
    if (in_tuser) begin
      a_ph = lzss_pkg::PH_TYPE; a_ctrl = '0; a_bits = '0; a_lf = '0; a_rm = '0;
      a_stop = 1'b0; a_cnt = '0;
    end
    lit = 1'b0; mstart = 1'b0; endm = 1'b0; badm = 1'b0;
    mdist = '0; mlen = '0;
    wrd = {in_tdata, wlo_r};
    h_ph = a_ph; h_ctrl = a_ctrl; h_bits = a_bits; h_lf = a_lf; h_rm = a_rm;
    if (!a_stop) begin
      unique case (a_ph)
        lzss_pkg::PH_LIT: begin
          lit = 1'b1; h_ph = lzss_pkg::PH_TYPE;
        end
        lzss_pkg::PH_SOFF: begin
          mstart = 1'b1; mdist = 14'd256 - {6'd0, in_tdata};
          mlen = {7'd0, a_lf} + 9'd2; h_ph = lzss_pkg::PH_TYPE;
        end
        lzss_pkg::PH_WLO: h_ph = lzss_pkg::PH_WHI;
        lzss_pkg::PH_WHI: begin
          if (wrd == 16'd0) begin
            endm = 1'b1;
          end else begin
            mdist = 14'd8192 - {1'b0, wrd[15:3]};
            if (wrd[2:0] != 3'd0) begin
              mstart = 1'b1; mlen = {6'd0, wrd[2:0]} + 9'd2;
              h_ph = lzss_pkg::PH_TYPE;
            end else begin
              h_ph = lzss_pkg::PH_EXT;
            end
          end
        end
        lzss_pkg::PH_EXT: begin
          mstart = 1'b1; mdist = dist_r; mlen = {1'b0, in_tdata} + 9'd1;
          h_ph = lzss_pkg::PH_TYPE;
        end
        default: begin
          h_ctrl = in_tdata; h_bits = 4'd8;
        end
      endcase
      if (mstart && (mdist == 14'd0 || 32'(mdist) > 32'(WINDOW_BYTES) ||
                     32'(mdist) > 32'(a_cnt))) begin
        badm = 1'b1; mstart = 1'b0;
      end
    end
  end

  lzss_pkg::phase_t n_ph;
  logic [7:0] n_ctrl;
  logic [3:0] n_bits;
  logic [1:0] n_lf;
  logic [8:0] n_rm;
  always_comb adv(h_ph, h_ctrl, h_bits, h_lf, h_rm, n_ph, n_ctrl, n_bits, n_lf, n_rm);

  // ---- copy engine ----
  logic [AW-1:0] rd_addr;
  logic [7:0] rd_byte;
  logic [7:0] wr_byte;
  logic wr_en;
  logic issue;
  logic obuf_free;
  assign obuf_free = !obuf_v_r || out_tready;
  assign rd_addr = wp_r - dist_r[AW-1:0];
  assign rd_byte = fwd_r ? fwd_d_r : rdata_r;
  // Issue a read in COPY when bytes remain, no read is pending and the word group has room.
  assign issue = (st_r == lzss_pkg::ST_COPY) && rem_r != 9'd0 && !rd_pend_r &&
                 gcnt_r != 3'd4;
  assign wr_en = (acc && lit) || rd_pend_r;
  assign wr_byte = rd_pend_r ? rd_byte : in_tdata;

  always_ff @(posedge clk) begin
    if (issue) rdata_r <= hist[rd_addr];
    if (wr_en) hist[wp_r] <= wr_byte;
  end

  always_ff @(posedge clk) begin
    fwd_r   <= (rd_addr == wp_r - AW'(1)) && dist_r == 14'd1;
    fwd_d_r <= lastw_r;
    if (wr_en) lastw_r <= wr_byte;
  end

  // ---- main sequencer ----
  logic gfull, copy_done;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lzss_pkg::ST_IDLE; ph_r <= lzss_pkg::PH_TYPE;
      ctrl_r <= '0; bits_r <= '0; lenf_r <= '0; wlo_r <= '0; dist_r <= '0;
      rem_r <= '0; hrm_r <= '0; wp_r <= '0; cnt_r <= '0; stop_r <= 1'b0;
      rd_pend_r <= 1'b0; gcnt_r <= '0; end_r <= 1'b0; bad_r <= 1'b0;
      last_r <= 1'b0; obuf_v_r <= 1'b0; obuf_l_r <= 1'b0;
    end else begin
      if (st_r == lzss_pkg::ST_EMIT && obuf_free) begin
        obuf_v_r <= 1'b1;
      end else if (obuf_v_r && out_tready) begin
        obuf_v_r <= 1'b0;
      end
      rd_pend_r <= issue;
      if (wr_en) begin
        wp_r <= (32'(wp_r) + 1 >= WINDOW_BYTES) ? '0 : wp_r + AW'(1);
        if (cnt_r != CMAX) cnt_r <= cnt_r + COUNT_BITS'(1);
      end
      if (rd_pend_r) begin
        grp_r[gcnt_r[1:0]] <= rd_byte;
        gcnt_r <= gcnt_r + 3'd1;
      end
      unique case (st_r)
        lzss_pkg::ST_IDLE: begin
          if (acc) begin
            ph_r <= n_ph; ctrl_r <= n_ctrl; bits_r <= n_bits; lenf_r <= n_lf;
            hrm_r <= n_rm; rem_r <= mstart ? mlen : n_rm;
            stop_r <= a_stop || endm || badm;
            if (in_tuser) begin
              wp_r <= '0; cnt_r <= '0;
            end
            if (!a_stop && a_ph == lzss_pkg::PH_WLO) wlo_r <= in_tdata;
            if (mstart || (!a_stop && a_ph == lzss_pkg::PH_WHI && !endm))
              dist_r <= mdist;
            end_r <= endm || badm; bad_r <= badm;
            if (lit) begin
              grp_r[0] <= in_tdata; gcnt_r <= 3'd1;
              st_r <= lzss_pkg::ST_EMIT; last_r <= 1'b1;
            end else begin
              gcnt_r <= '0;
              if (mstart) begin
                st_r <= lzss_pkg::ST_COPY;
              end else if (endm || badm) begin
                st_r <= lzss_pkg::ST_EMIT; last_r <= 1'b1;
              end
            end
          end
        end
        lzss_pkg::ST_COPY: begin
          if (issue) rem_r <= rem_r - 9'd1;
          if (gfull || copy_done) begin
            st_r <= lzss_pkg::ST_EMIT;
            last_r <= copy_done;
          end
        end
        lzss_pkg::ST_EMIT: begin
          if (obuf_free) begin
            obuf_l_r <= last_r;
            gcnt_r <= '0;
            st_r <= last_r ? lzss_pkg::ST_IDLE : lzss_pkg::ST_COPY;
            if (last_r) rem_r <= hrm_r;
          end
        end
        default: st_r <= lzss_pkg::ST_IDLE;
      endcase
    end
  end

  // Group is ready when four bytes are in, or copy ended with bytes pending.
  assign gfull = !rd_pend_r && gcnt_r == 3'd4 && rem_r != 9'd0;
  assign copy_done = !rd_pend_r && !issue && rem_r == 9'd0;

  // Count shown includes the bytes in this word; cnt_r has already advanced.
  always_ff @(posedge clk) begin
    if (st_r == lzss_pkg::ST_EMIT && obuf_free) begin
      obuf_r <= {3'd0, 24'(cnt_r), bad_r && last_r, end_r && last_r, gcnt_r,
                 (gcnt_r > 3'd3) ? grp_r[3] : 8'd0,
                 (gcnt_r > 3'd2) ? grp_r[2] : 8'd0,
                 (gcnt_r > 3'd1) ? grp_r[1] : 8'd0,
                 (gcnt_r > 3'd0) ? grp_r[0] : 8'd0};
    end
  end

  // A copy with an end word: end word pushed separately after data.
  assign out_tvalid = obuf_v_r;
  assign out_tdata  = obuf_r;
  assign out_tlast  = obuf_l_r;

  ap_one_src: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc && st_r != lzss_pkg::ST_IDLE)) else $error("input taken while busy");
  ap_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    gcnt_r <= 3'd4) else $error("group overflow");
  ap_issue: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> rd_pend_r) else $error("read not tracked");
endmodule
`default_nettype wire

### tb/sv/lzss_decode_checker.sv
// Checker for the LZSS byte stream decompressor: watches both channels, keeps its own
// decoder state and history, and compares every output word. Depends on lzss_pkg.
`timescale 1ns / 1ps
module lzss_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_words
);
  localparam int Window = 8192;
  localparam logic [23:0] CountMax = 24'hFFFFFF;

  typedef struct packed {
    logic        last;
    logic [63:0] data;
  } out_word_t;

  out_word_t        expected_words[$];
  logic [7:0]       hist[Window];
  logic [7:0]       ctl_bits;
  logic [3:0]       bits_avail;
  lzss_pkg::phase_t phase;
  logic [1:0]       len_field;
  logic [7:0]       word_lo;
  int               distance;
  int               remaining;
  int               wr_ptr;
  logic [23:0]      written;
  logic             halted;
  logic [7:0]       group[4];
  int               group_len;
  int               step_first;

  assign pending_words = expected_words.size();

  function automatic void clear_state();
    ctl_bits = '0; bits_avail = '0; phase = lzss_pkg::PH_TYPE; len_field = '0;
    word_lo = '0; distance = 0; remaining = 0; wr_ptr = 0; written = '0;
    halted = 1'b0;
  endfunction

  function automatic void queue_group(logic stop, logic bad);
    out_word_t w;
    w.last = 1'b0;
    w.data = '0;
    for (int i = 0; i < 4; i++)
      if (i < group_len) w.data[8*i +: 8] = group[i];
    w.data[34:32] = group_len[2:0];
    w.data[35]    = stop;
    w.data[36]    = bad;
    w.data[60:37] = written;
    expected_words.push_back(w);
    group_len = 0;
  endfunction

  function automatic void emit_byte(logic [7:0] v);
    hist[wr_ptr] = v;
    wr_ptr = (wr_ptr + 1) % Window;
    if (written != CountMax) written++;
    group[group_len] = v;
    group_len++;
    if (group_len == 4) queue_group(1'b0, 1'b0);
  endfunction

  // Consume header bits while the header still wants one and any are left.
  function automatic void walk_header();
    logic b;
    while (phase inside {lzss_pkg::PH_TYPE, lzss_pkg::PH_KIND, lzss_pkg::PH_LEN} &&
           bits_avail != 0) begin
      b = ctl_bits[0];
      ctl_bits = ctl_bits >> 1;
      bits_avail--;
      case (phase)
        lzss_pkg::PH_TYPE: phase = b ? lzss_pkg::PH_LIT : lzss_pkg::PH_KIND;
        lzss_pkg::PH_KIND: begin
          if (b) begin
            phase = lzss_pkg::PH_WLO;
          end else begin
            phase = lzss_pkg::PH_LEN; len_field = '0; remaining = 0;
          end
        end
        default: begin
          len_field = {len_field[0], b};
          remaining++;
          if (remaining >= 2) phase = lzss_pkg::PH_SOFF;
        end
      endcase
    end
  endfunction

  function automatic logic copy_back();
    int rd;
    if (distance == 0 || distance > Window || distance > written) return 1'b0;
    while (remaining > 0) begin
      rd = (wr_ptr - distance + Window) % Window;
      emit_byte(hist[rd]);
      remaining--;
    end
    return 1'b1;
  endfunction

  function automatic void decode_byte(logic [7:0] v, logic fresh);
    logic stop, bad;
    int w;
    stop = 1'b0; bad = 1'b0;
    step_first = expected_words.size();
    group_len = 0;
    if (fresh) clear_state();
    if (halted) return;
    case (phase)
      lzss_pkg::PH_LIT: begin
        emit_byte(v); phase = lzss_pkg::PH_TYPE;
      end
      lzss_pkg::PH_SOFF: begin
        distance = 256 - v;
        remaining = len_field + 2;
        bad = !copy_back();
        phase = lzss_pkg::PH_TYPE;
      end
      lzss_pkg::PH_WLO: begin
        word_lo = v; phase = lzss_pkg::PH_WHI;
      end
      lzss_pkg::PH_WHI: begin
        w = {v, word_lo};
        if (w == 0) begin
          stop = 1'b1;
        end else begin
          distance = 8192 - (w >> 3);
          if ((w & 7) != 0) begin
            remaining = (w & 7) + 2;
            bad = !copy_back();
            phase = lzss_pkg::PH_TYPE;
          end else begin
            phase = lzss_pkg::PH_EXT;
          end
        end
      end
      lzss_pkg::PH_EXT: begin
        remaining = v + 1;
        bad = !copy_back();
        phase = lzss_pkg::PH_TYPE;
      end
      default: begin
        ctl_bits = v; bits_avail = 4'd8;
      end
    endcase
    if (bad) stop = 1'b1;
    if (stop) begin
      halted = 1'b1;
      if (group_len > 0) queue_group(1'b0, 1'b0);
      queue_group(1'b1, bad);
    end else begin
      walk_header();
      if (group_len > 0) queue_group(1'b0, 1'b0);
    end
    // tlast marks the final word caused by this byte
    if (expected_words.size() > step_first)
      expected_words[expected_words.size() - 1].last = 1'b1;
  endfunction

  function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      clear_state();
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word %0h", out_tdata);
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          compare_field("byte_0", e.data[7:0], out_tdata[7:0]);
          compare_field("byte_1", e.data[15:8], out_tdata[15:8]);
          compare_field("byte_2", e.data[23:16], out_tdata[23:16]);
          compare_field("byte_3", e.data[31:24], out_tdata[31:24]);
          compare_field("byte_count", e.data[34:32], out_tdata[34:32]);
          compare_field("stream_end", e.data[35], out_tdata[35]);
          compare_field("bad_reference", e.data[36], out_tdata[36]);
          compare_field("total_bytes", e.data[60:37], out_tdata[60:37]);
          compare_field("last_of_run", e.last, out_tlast);
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
    end
  end
endmodule

### tb/sv/testbench.sv
// Top of the LZSS decompressor testbench: clock, reset, compressed-stream stimulus and
// output back-pressure. Depends on lzss_pkg, lzss_decode_checker and the RTL top.
`timescale 1ns / 1ps
module testbench;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending_words;
  logic        sink_hold = 1'b0;   // long receiver stall, raised by the stimulus

  // Byte stream under construction: data and the new_stream flag per byte.
  logic [7:0]  stream_bytes[$];
  logic        stream_flags[$];
  int          literal_count;      // decoded length of the stream being built

  always #6 clk = ~clk;

  lzss_byte_stream_decompressor u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  lzss_decode_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  function automatic int pick_gap();
    // mostly back to back, sometimes short, rarely long
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, held off entirely while a long hold is requested.
  always @(posedge clk) begin
    if (!rst_n || sink_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) < 70);
    end
  end

  // Send one word; hold it until the block takes it, then maybe idle.
  task automatic send_word(logic [7:0] d, logic fresh);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= fresh;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic flush_stream();
    while (stream_bytes.size() > 0)
      send_word(stream_bytes.pop_front(), stream_flags.pop_front());
  endtask

  // Build one stream of n tokens with random content, with an occasional bad distance
  // when allow_bad is set. Control bytes fall wherever a ninth bit is needed, even inside a match header.
  task automatic build_stream(int n_tokens, bit with_end, bit allow_bad);
    logic [7:0] ctl;
    int         bits_in_ctl;
    int         ctl_idx;
    int         kind;
    int         back_dist;
    int         len;
    logic [15:0] w;
    bits_in_ctl = 8;
    ctl_idx = -1;
    literal_count = 0;
    for (int t = 0; t <= n_tokens; t++) begin
      // kinds: 0 literal, 1 short match, 2 long match, 3 long extended, 4 end
      if (t == n_tokens) kind = with_end ? 4 : -1;
      else if (literal_count == 0) kind = 0;
      else kind = $urandom_range(0, 9) < 4 ? 0 : $urandom_range(1, 3);
      if (kind < 0) break;
      for (int b = 0; b < (kind == 0 ? 1 : (kind == 1 ? 4 : 2)); b++) begin
        logic bitv;
        case (kind)
          0: bitv = 1'b1;
          1: bitv = 1'b0;  // 0,0 then length bits below
          default: bitv = (b == 1);
        endcase
        if (kind == 1 && b >= 2) bitv = $urandom_range(0, 1);
        if (bits_in_ctl == 8) begin
          stream_bytes.push_back(8'h00);
          stream_flags.push_back(1'b0);
          ctl_idx = stream_bytes.size() - 1;
          bits_in_ctl = 0;
        end
        stream_bytes[ctl_idx][bits_in_ctl] = bitv;
        if (kind == 1 && b >= 2) len = (b == 2) ? {bitv, 1'b0} : len | bitv;
        bits_in_ctl++;
      end
      back_dist = (allow_bad && $urandom_range(0, 19) == 0)
                ? literal_count + $urandom_range(1, 4)
                : $urandom_range(1, literal_count > 0 ? literal_count : 1);
      case (kind)
        0: begin
          stream_bytes.push_back($urandom); stream_flags.push_back(1'b0);
          literal_count++;
        end
        1: begin
          if (back_dist > 256) back_dist = $urandom_range(1, 256);
          stream_bytes.push_back(8'(256 - back_dist)); stream_flags.push_back(1'b0);
          literal_count += len + 2;
        end
        2, 3: begin
          len = (kind == 2) ? $urandom_range(1, 7) : 0;
          w = {13'(8192 - back_dist), 3'(len)};
          stream_bytes.push_back(w[7:0]);  stream_flags.push_back(1'b0);
          stream_bytes.push_back(w[15:8]); stream_flags.push_back(1'b0);
          if (kind == 3) begin
            len = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 20);
            stream_bytes.push_back(len[7:0]); stream_flags.push_back(1'b0);
            literal_count += len + 1;
          end else begin
            literal_count += len + 2;
          end
        end
        default: begin
          stream_bytes.push_back(8'h00); stream_flags.push_back(1'b0);
          stream_bytes.push_back(8'h00); stream_flags.push_back(1'b0);
        end
      endcase
    end
    stream_flags[0] = 1'b1;
  endtask

  // Drop the input and hold until every expected word has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    int sent;
    bit long_hold_done;
    long_hold_done = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: literals 00/FF, a short match with a bad reference and a byte ignored
    // after that stop, long match max length via extended byte, end marker.
    send_word(8'b0000_0011, 1'b1);   // 1 literal, 1 literal, then 00 short
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    // control bits so far used 2; the remaining 0,0,0,0 start a short match of length 2
    // the next word opens a fresh stream, so that match is never finished
    send_word(8'b1010_0000, 1'b1);   // fresh stream: 0,0 short,0,0 len -> bad ref
    send_word(8'h01, 1'b0);          // distance 255 beyond start: bad reference
    send_word(8'h55, 1'b0);          // ignored after stop
    // Fresh stream: literal AA, long match ext len 255 dist 1, end marker.
    // bits: 1 | 0 1 | 0 1
    send_word(8'b0001_0101 ^ 8'b0000_0000, 1'b1);
    send_word(8'hAA, 1'b0);
    send_word(8'hF8, 1'b0);          // W = 0xFFF8: dist 1, length field 0
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);          // 256 bytes of AA
    send_word(8'h00, 1'b0);          // zero word ends the stream
    send_word(8'h00, 1'b0);
    // Eight literal bits in one control byte; only seven literals follow, so the next byte is the eighth
    send_word(8'hFF, 1'b1);
    for (int i = 0; i < 7; i++) send_word(8'(i * 37), 1'b0);
    send_word(8'b0000_1100, 1'b0);   // taken as the eighth literal
    send_word(8'hFE, 1'b0);          // new control byte: 0 then 1 opens a long match header that is left open
    wait_drained();

    // Random: mostly well-formed streams, a few broken or noisy ones.
    sent = 0;
    while (sent < 250) begin
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 6; i++) begin
          stream_bytes.push_back($urandom);
          stream_flags.push_back(i == 0);
        end
      end else begin
        build_stream($urandom_range(3, 20), $urandom_range(0, 3) != 0, 1'b1);
      end
      sent += stream_bytes.size();
      if (sent > 100 && !long_hold_done) begin
        // stall the receiver for a long stretch while bytes keep coming
        long_hold_done = 1'b1;
        sink_hold <= 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            sink_hold <= 1'b0;
          end
        join_none
      end
      flush_stream();
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
    end
    in_tvalid <= 1'b0;
    wait (!sink_hold);
    wait_drained();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
